// ----- rtl/ocd_pkg.sv -----
// package for occupancy_corner_detect: request and result structs,
// register indexes, widths and the grid mask struct; imported by all modules
`default_nettype none

package ocd_pkg;

  localparam int unsigned MAX_DIM_DEF  = 1024;
  localparam int unsigned GRID_W       = 11;
  localparam int unsigned COORD_W      = 10;
  localparam int unsigned WIN_SIDE     = 5;
  localparam int unsigned WIN_BITS     = WIN_SIDE * WIN_SIDE;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned GRID_RST     = 1024;
  localparam int unsigned GRID_CAP     = (1 << GRID_W) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 8'd0,
    REG_GRID_COLS = 8'd1
  } ocd_reg_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] window_bits;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_col;
  } ocd_in_t;

  typedef struct packed {
    logic centre_is_corner;
    logic neighbour_is_corner;
  } ocd_out_t;

  // per window row / column: inside the grid
  typedef struct packed {
    logic [WIN_SIDE-1:0] row_ok;
    logic [WIN_SIDE-1:0] col_ok;
  } ocd_mask_t;

endpackage

`default_nettype wire

// ----- rtl/ocd_grid_mask.sv -----
// in-grid mask for the five window rows and five window columns
// depends on ocd_pkg
`default_nettype none

module ocd_grid_mask
  import ocd_pkg::*;
(
  input  wire logic [COORD_W-1:0] cell_row,
  input  wire logic [COORD_W-1:0] cell_col,
  input  wire logic [GRID_W-1:0]  grid_rows,
  input  wire logic [GRID_W-1:0]  grid_cols,
  output ocd_mask_t               mask
);

  localparam int unsigned POS_W = GRID_W + 1;
  localparam int unsigned HALF  = WIN_SIDE / 2;

  logic [POS_W-1:0] row_lim;
  logic [POS_W-1:0] col_lim;

  // position biased by HALF so offsets stay non-negative
  always_comb begin
    logic [POS_W-1:0] rpos;
    logic [POS_W-1:0] cpos;
    row_lim = {1'b0, grid_rows} + POS_W'(HALF);
    col_lim = {1'b0, grid_cols} + POS_W'(HALF);
    for (int k = 0; k < WIN_SIDE; k++) begin
      rpos = POS_W'(cell_row) + POS_W'(k);
      cpos = POS_W'(cell_col) + POS_W'(k);
      mask.row_ok[k] = (rpos >= POS_W'(HALF)) && (rpos < row_lim);
      mask.col_ok[k] = (cpos >= POS_W'(HALF)) && (cpos < col_lim);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ocd_corner_eval.sv -----
// corner test for the centre cell and its eight neighbours
// depends on ocd_pkg
`default_nettype none

module ocd_corner_eval
  import ocd_pkg::*;
(
  input  wire logic [WIN_BITS-1:0] window_bits,
  input  wire ocd_mask_t           mask,
  output ocd_out_t                 res
);

  localparam int unsigned HALF = WIN_SIDE / 2;

  function automatic logic occ(input logic [WIN_BITS-1:0] w, input ocd_mask_t m,
                               input int r, input int c);
    occ = w[r * WIN_SIDE + c] & m.row_ok[r] & m.col_ok[c];
  endfunction

  logic [8:0] corner;

  always_comb begin
    int r;
    int c;
    logic hit;
    for (int i = 0; i < 9; i++) begin
      r   = HALF - 1 + i / 3;
      c   = HALF - 1 + i % 3;
      hit = 1'b0;
      for (int q = 0; q < 4; q++) begin
        if (mask.row_ok[(q < 2) ? r - 1 : r + 1] &&
            mask.col_ok[(q % 2 == 0) ? c - 1 : c + 1] &&
            !occ(window_bits, mask, r, (q % 2 == 0) ? c - 1 : c + 1) &&
            !occ(window_bits, mask, (q < 2) ? r - 1 : r + 1,
                 (q % 2 == 0) ? c - 1 : c + 1) &&
            !occ(window_bits, mask, (q < 2) ? r - 1 : r + 1, c)) begin
          hit = 1'b1;
        end
      end
      corner[i] = occ(window_bits, mask, r, c) & hit;
    end
    res.centre_is_corner    = corner[4];
    res.neighbour_is_corner = |{corner[8:5], corner[3:0]};
  end

endmodule

`default_nettype wire

// ----- rtl/occupancy_corner_detect.sv -----
// Corner detector on a binary occupancy grid. One request (5x5 window plus
// centre row and column) is taken in every cycle in which start is high and
// busy is low; busy is high only in reset and the cycle after it. The result
// appears on out_res for one cycle, marked by out_valid, behind the input and
// result registers; it cannot be stalled. The cost is one input register and
// one result register around the mask and corner logic. Grid size registers are
// written over the cfg port, which is always ready; writes above MAX_DIM
// saturate and unknown indexes are ignored.
// depends on ocd_pkg, ocd_grid_mask, ocd_corner_eval
`default_nettype none

module occupancy_corner_detect
  import ocd_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ocd_in_t              in_req,
  output logic                      out_valid,
  output ocd_out_t                  out_res,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GRID_W-1:0]    cfg_wdata
);

  localparam int unsigned SAT     = (MAX_DIM > GRID_CAP) ? GRID_CAP : MAX_DIM;
  localparam int unsigned RST_DIM = (GRID_RST > SAT) ? SAT : GRID_RST;
  localparam logic [GRID_W-1:0] SAT_V = GRID_W'(SAT);
  localparam logic [GRID_W-1:0] RST_V = GRID_W'(RST_DIM);

  logic              busy_r;
  logic [GRID_W-1:0] grid_rows_r;
  logic [GRID_W-1:0] grid_cols_r;
  logic [GRID_W-1:0] cfg_val;
  ocd_in_t           req_r;
  logic              req_vld_r;
  ocd_out_t          res_r;
  ocd_out_t          res_nxt;
  logic              res_vld_r;
  ocd_mask_t         mask;
  logic              accept;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy_r;
  assign cfg_val   = (cfg_wdata > SAT_V) ? SAT_V : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= RST_V;
      grid_cols_r <= RST_V;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_val;
        REG_GRID_COLS: grid_cols_r <= cfg_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      req_vld_r <= accept;
      res_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (req_vld_r) begin
      res_r <= res_nxt;
    end
  end

  ocd_grid_mask u_mask (
    .cell_row  (req_r.cell_row),
    .cell_col  (req_r.cell_col),
    .grid_rows (grid_rows_r),
    .grid_cols (grid_cols_r),
    .mask      (mask)
  );

  ocd_corner_eval u_eval (
    .window_bits (req_r.window_bits),
    .mask        (mask),
    .res         (res_nxt)
  );

  assign out_valid = res_vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ----- rtl/ocd_checker.sv -----
// port-level checks for occupancy_corner_detect and the bind that attaches them
// depends on ocd_pkg
`default_nettype none

module ocd_checker
  import ocd_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire ocd_in_t  in_req,
  input wire logic     out_valid,
  input wire ocd_out_t out_res
);

  // centre and its eight neighbours in the window
  localparam logic [WIN_BITS-1:0] CENTRE_BIT = WIN_BITS'(1) << (WIN_BITS / 2);
  localparam logic [WIN_BITS-1:0] NEIGH_BITS = WIN_BITS'(25'h0729C0);

  logic acc;
  assign acc = start & ~busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##2 out_valid)
    else $error("request without result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 2))
    else $error("result without request");

  a_centre_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.centre_is_corner |->
      $past((in_req.window_bits & CENTRE_BIT) != '0, 2))
    else $error("corner on a free centre");

  a_neigh_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.neighbour_is_corner |->
      $past((in_req.window_bits & NEIGH_BITS) != '0, 2))
    else $error("neighbour corner with all neighbours free");

endmodule

bind occupancy_corner_detect ocd_checker u_ocd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire
